[rtl/kgrw_pkg.sv]
// Shared widths, defaults and codes for the k-NN graph radius walk.
package kgrw_pkg;

  localparam int unsigned IDX_W   = 10;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned CRD_W   = 16;
  localparam int unsigned RAD_W   = 34;
  localparam int unsigned EPOCH_W = 8;

  localparam int unsigned DEF_POINT_COUNT    = 1024;
  localparam int unsigned DEF_NEIGHBOR_COUNT = 8;
  localparam int unsigned DEF_COORD_BITS     = 16;

  typedef enum logic [1:0] {
    ACT_LOAD_POINT = 2'd0,
    ACT_LOAD_NBR   = 2'd1,
    ACT_START      = 2'd2,
    ACT_NEXT       = 2'd3
  } action_e;

  typedef struct packed {
    logic busy;
    logic done;
  } dist_status_t;

endpackage

[rtl/kgrw_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module kgrw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/kgrw_dist.sv]
// Shared squarer and accumulator: squared 3-D distance, one axis at a time.
module kgrw_dist #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [3*COORD_BITS-1:0]   a_i,
  input  logic [3*COORD_BITS-1:0]   b_i,
  output logic [2*COORD_BITS+1:0]   sum_o,
  output kgrw_pkg::dist_status_t    status_o
);
  import kgrw_pkg::*;

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned SUM_W = 2 * CB + 2;

  logic              running_q, running_d;
  logic [1:0]        k_q, k_d;
  logic [2*CB-1:0]   prod_q;
  logic [SUM_W-1:0]  acc_q;
  logic signed [CB:0]     diff;
  logic signed [2*CB+1:0] sq;

  // one axis per cycle, a and b held stable by the caller
  always_comb begin
    unique case (k_q)
      2'd0:    diff = $signed({a_i[CB-1], a_i[CB-1:0]}) - $signed({b_i[CB-1], b_i[CB-1:0]});
      2'd1:    diff = $signed({a_i[2*CB-1], a_i[2*CB-1:CB]})
                    - $signed({b_i[2*CB-1], b_i[2*CB-1:CB]});
      2'd2:    diff = $signed({a_i[3*CB-1], a_i[3*CB-1:2*CB]})
                    - $signed({b_i[3*CB-1], b_i[3*CB-1:2*CB]});
      default: diff = '0;
    endcase
    sq = diff * diff;
  end

  always_comb begin
    running_d = running_q;
    k_d       = k_q;
    if (start_i) begin
      running_d = 1'b1;
      k_d       = 2'd0;
    end else if (running_q) begin
      k_d = k_q + 2'd1;
      if (k_q == 2'd3) begin
        running_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      k_q       <= 2'd0;
    end else begin
      running_q <= running_d;
      k_q       <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (running_q) begin
      prod_q <= sq[2*CB-1:0];
      if (k_q == 2'd1) begin
        acc_q <= SUM_W'(prod_q);
      end else if (k_q != 2'd0) begin
        acc_q <= acc_q + SUM_W'(prod_q);
      end
    end
  end

  assign sum_o         = acc_q;
  assign status_o.busy = running_q;
  assign status_o.done = running_q && (k_q == 2'd3);

endmodule

[rtl/knn_graph_radius_walk.sv]
// Top level: depth-first radius walk over a k-nearest-neighbour point graph.
// Use:
//   Input channel (in_valid_i/in_ready_o) takes one beat per item. Action
//   load point and load neighbour write the stores in the cycle they are accepted, no result.
//   Start clears the walk and pushes the centre; start and next each pop one
//   point and return it on the output channel, or done_res when the stack
//   is empty (member_index_o then 0).
//   Config channel (cfg_valid_i/cfg_ready_o) sets squared_radius, always ready.
// Sequence:
//   A next pops in S_POP and registers the result beat in S_POPW; a start
//   passes S_START first. A walk step then holds in_ready_o low while it works
//   through each neighbour slot: a neighbour read, a visited/coordinate read,
//   the shared squarer and a push decision (a visited neighbour skips the
//   squarer and the push). Loads keep in_ready_o high.
//   Visited marks are epoch tags in RAM; every 2^EPOCH_W-1 starts, and after
//   reset, a clearing pass over all POINT_COUNT entries runs with in_ready_o low.
// Stall:
//   The result sits in an output register; the block idles with ready high
//   while it waits, and holds a later step at its pop until the register frees.
module knn_graph_radius_walk #(
  parameter int unsigned POINT_COUNT    = kgrw_pkg::DEF_POINT_COUNT,
  parameter int unsigned NEIGHBOR_COUNT = kgrw_pkg::DEF_NEIGHBOR_COUNT,
  parameter int unsigned COORD_BITS     = kgrw_pkg::DEF_COORD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [kgrw_pkg::IDX_W-1:0]    point_index_i,
  input  logic [kgrw_pkg::SLOT_W-1:0]   neighbor_slot_i,
  input  logic [kgrw_pkg::IDX_W-1:0]    neighbor_index_i,
  input  logic signed [kgrw_pkg::CRD_W-1:0] coord_x_i,
  input  logic signed [kgrw_pkg::CRD_W-1:0] coord_y_i,
  input  logic signed [kgrw_pkg::CRD_W-1:0] coord_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kgrw_pkg::IDX_W-1:0]    member_index_o,
  output logic                          done_res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kgrw_pkg::RAD_W-1:0]    cfg_squared_radius_i
);
  import kgrw_pkg::*;

  localparam int unsigned PW    = $clog2(POINT_COUNT);
  localparam int unsigned NAW   = $clog2(POINT_COUNT * NEIGHBOR_COUNT);
  localparam int unsigned SW    = $clog2(NEIGHBOR_COUNT + 1);
  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned SUM_W = 2 * CB + 2;
  localparam int unsigned CMP_W = (SUM_W > RAD_W) ? SUM_W : RAD_W;
  localparam logic [PW:0]      DEPTH_MAX = (PW + 1)'(POINT_COUNT);
  localparam logic [PW-1:0]    LAST_PT   = PW'(POINT_COUNT - 1);
  localparam logic [SW-1:0]    LAST_SLOT = SW'(NEIGHBOR_COUNT);
  localparam logic [EPOCH_W-1:0] EPOCH_TOP = '1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_START, S_POP, S_POPW, S_NRD, S_NWAIT, S_VWAIT, S_DIST, S_CMP
  } state_e;

  state_e              state_q;
  logic [RAD_W-1:0]    radius_q;
  logic [EPOCH_W-1:0]  epoch_q;
  logic [PW-1:0]       clr_q;
  logic                start_pend_q;
  logic [PW:0]         depth_q;
  logic [IDX_W-1:0]    center_q, cur_q, nb_q, start_idx_q;
  logic [SW-1:0]       slot_q;
  logic [3*CB-1:0]     ccoord_q;
  logic                out_valid_q, done_q;
  logic [IDX_W-1:0]    member_q;

  // RAM ports
  logic               crd_we, crd_re;
  logic [PW-1:0]      crd_waddr, crd_raddr;
  logic [3*CB-1:0]    crd_wdata, crd_rdata;
  logic               nbr_we, nbr_re;
  logic [NAW-1:0]     nbr_waddr, nbr_raddr;
  logic [IDX_W-1:0]   nbr_rdata;
  logic               vis_we, vis_re;
  logic [PW-1:0]      vis_waddr, vis_raddr;
  logic [EPOCH_W-1:0] vis_wdata, vis_rdata;
  logic               stk_we, stk_re;
  logic [PW-1:0]      stk_waddr, stk_raddr;
  logic [IDX_W-1:0]   stk_wdata, stk_rdata;

  logic               dist_start;
  logic [SUM_W-1:0]   dist_sum;
  dist_status_t       dist_st;

  logic in_acc, out_busy, nb_ok, center_ok, push_ok;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_busy    = out_valid_q && !out_ready_i;
  assign nb_ok       = 32'(nbr_rdata) < POINT_COUNT;
  assign center_ok   = 32'(start_idx_q) < POINT_COUNT;
  assign push_ok     = CMP_W'(dist_sum) < CMP_W'(radius_q);

  // RAM port steering
  always_comb begin
    crd_we    = in_acc && (action_e'(action_i) == ACT_LOAD_POINT)
                && (32'(point_index_i) < POINT_COUNT);
    crd_waddr = PW'(point_index_i);
    crd_wdata = {coord_z_i[CB-1:0], coord_y_i[CB-1:0], coord_x_i[CB-1:0]};
    crd_re    = (state_q == S_POP) || (state_q == S_NWAIT && nb_ok);
    crd_raddr = (state_q == S_POP) ? PW'(center_q) : PW'(nbr_rdata);

    nbr_we    = in_acc && (action_e'(action_i) == ACT_LOAD_NBR)
                && (32'(point_index_i) < POINT_COUNT)
                && (32'(neighbor_slot_i) < NEIGHBOR_COUNT);
    nbr_waddr = NAW'(point_index_i) * NAW'(NEIGHBOR_COUNT) + NAW'(neighbor_slot_i);
    nbr_re    = (state_q == S_NRD) && (slot_q != LAST_SLOT);
    nbr_raddr = NAW'(cur_q) * NAW'(NEIGHBOR_COUNT) + NAW'(slot_q);

    vis_re    = (state_q == S_NWAIT) && nb_ok;
    vis_raddr = PW'(nbr_rdata);
    vis_we    = 1'b0;
    vis_waddr = PW'(nb_q);
    vis_wdata = epoch_q;
    stk_we    = 1'b0;
    stk_waddr = depth_q[PW-1:0];
    stk_wdata = nb_q;
    unique case (state_q)
      S_CLR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_q;
        vis_wdata = '0;
      end
      S_START: begin
        vis_we    = center_ok;
        vis_waddr = PW'(start_idx_q);
        stk_we    = center_ok;
        stk_waddr = '0;
        stk_wdata = start_idx_q;
      end
      S_CMP: begin
        vis_we = push_ok;
        stk_we = push_ok && (depth_q < DEPTH_MAX);
      end
      default: ;
    endcase
    stk_re    = (state_q == S_POP) && !out_busy && (depth_q != '0);
    stk_raddr = PW'(depth_q - (PW + 1)'(1));
  end

  assign dist_start = (state_q == S_VWAIT) && (vis_rdata != epoch_q);

  // sequencer, stack depth and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      radius_q     <= '0;
      epoch_q      <= '0;
      clr_q        <= '0;
      start_pend_q <= 1'b0;
      depth_q      <= '0;
      center_q     <= '0;
      slot_q       <= '0;
      out_valid_q  <= 1'b0;
      done_q       <= 1'b0;
      member_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        radius_q <= cfg_squared_radius_i;
      end
      // a done beat issued at the pop takes over the freed register
      if (out_valid_q && out_ready_i && !(state_q == S_POP && depth_q == '0)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          if (clr_q == LAST_PT) begin
            clr_q        <= '0;
            epoch_q      <= EPOCH_W'(1);
            start_pend_q <= 1'b0;
            state_q      <= start_pend_q ? S_START : S_IDLE;
          end else begin
            clr_q <= clr_q + PW'(1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            start_idx_q <= point_index_i;
            priority case (action_e'(action_i))
              ACT_START: begin
                if (epoch_q == EPOCH_TOP) begin
                  start_pend_q <= 1'b1;
                  state_q      <= S_CLR;
                end else begin
                  epoch_q <= epoch_q + EPOCH_W'(1);
                  state_q <= S_START;
                end
              end
              ACT_NEXT: state_q <= S_POP;
              default:  ;
            endcase
          end
        end
        S_START: begin
          depth_q <= center_ok ? (PW + 1)'(1) : '0;
          if (center_ok) begin
            center_q <= start_idx_q;
          end
          state_q <= S_POP;
        end
        S_POP: begin
          if (!out_busy) begin
            if (depth_q == '0) begin
              out_valid_q <= 1'b1;
              done_q      <= 1'b1;
              member_q    <= '0;
              state_q     <= S_IDLE;
            end else begin
              depth_q <= depth_q - (PW + 1)'(1);
              state_q <= S_POPW;
            end
          end
        end
        S_POPW: begin
          cur_q       <= stk_rdata;
          ccoord_q    <= crd_rdata;
          out_valid_q <= 1'b1;
          done_q      <= 1'b0;
          member_q    <= stk_rdata;
          slot_q      <= '0;
          state_q     <= S_NRD;
        end
        S_NRD: begin
          state_q <= (slot_q == LAST_SLOT) ? S_IDLE : S_NWAIT;
        end
        S_NWAIT: begin
          nb_q <= nbr_rdata;
          if (nb_ok) begin
            state_q <= S_VWAIT;
          end else begin
            slot_q  <= slot_q + SW'(1);
            state_q <= S_NRD;
          end
        end
        S_VWAIT: begin
          if (vis_rdata == epoch_q) begin
            slot_q  <= slot_q + SW'(1);
            state_q <= S_NRD;
          end else begin
            state_q <= S_DIST;
          end
        end
        S_DIST: begin
          if (dist_st.done) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (stk_we) begin
            depth_q <= depth_q + (PW + 1)'(1);
          end
          slot_q  <= slot_q + SW'(1);
          state_q <= S_NRD;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign member_index_o = member_q;
  assign done_res_o     = done_q;

  kgrw_ram #(.WIDTH(3 * CB), .DEPTH(POINT_COUNT)) u_coord_ram (
    .clk_i, .we_i(crd_we), .waddr_i(crd_waddr), .wdata_i(crd_wdata),
    .re_i(crd_re), .raddr_i(crd_raddr), .rdata_o(crd_rdata)
  );

  kgrw_ram #(.WIDTH(IDX_W), .DEPTH(POINT_COUNT * NEIGHBOR_COUNT)) u_nbr_ram (
    .clk_i, .we_i(nbr_we), .waddr_i(nbr_waddr), .wdata_i(neighbor_index_i),
    .re_i(nbr_re), .raddr_i(nbr_raddr), .rdata_o(nbr_rdata)
  );

  kgrw_ram #(.WIDTH(EPOCH_W), .DEPTH(POINT_COUNT)) u_visit_ram (
    .clk_i, .we_i(vis_we), .waddr_i(vis_waddr), .wdata_i(vis_wdata),
    .re_i(vis_re), .raddr_i(vis_raddr), .rdata_o(vis_rdata)
  );

  kgrw_ram #(.WIDTH(IDX_W), .DEPTH(POINT_COUNT)) u_stack_ram (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .re_i(stk_re), .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  kgrw_dist #(.COORD_BITS(CB)) u_dist (
    .clk_i, .rst_ni, .start_i(dist_start), .a_i(ccoord_q), .b_i(crd_rdata),
    .sum_o(dist_sum), .status_o(dist_st)
  );

  // checks
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_MAX) else $error("stack depth beyond point count");

  a_done_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> member_q == '0) else $error("done beat with index");

  a_dist_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_st.busy |-> state_q == S_DIST) else $error("squarer busy outside walk");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POPW |-> !out_valid_q) else $error("result overwrote pending beat");

endmodule

[tb/sv/tb_top.sv]
// Testbench for knn_graph_radius_walk: directed table then random query walks, self-checked.
`timescale 1ns / 1ps

module tb_top;
  import kgrw_pkg::*;

  localparam int unsigned NPTS     = DEF_POINT_COUNT;
  localparam int unsigned NNBR     = DEF_NEIGHBOR_COUNT;
  localparam int unsigned SET_SIZE = 48;     // points that queries may ever reach
  localparam int unsigned SETTLE   = 200;    // > one walk step plus a clearing pass slice
  localparam int unsigned HOLD_LEN = 600;    // long receiver hold-off
  localparam longint      LIMIT    = 1500000;
  localparam logic [RAD_W-1:0] RAD_MAX = '1;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             done;
  } walk_res_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG, ROW_PRELOAD} row_kind_e;
  typedef enum logic [1:0] {CHK_NONE, CHK_TYPED, CHK_MODEL} row_chk_e;

  typedef struct {
    row_kind_e          kind;
    action_e            act;
    logic [IDX_W-1:0]   pidx;
    logic [SLOT_W-1:0]  slot;
    logic [IDX_W-1:0]   nidx;
    logic signed [15:0] x, y, z;
    logic [RAD_W-1:0]   radius;
    row_chk_e           chk;
    walk_res_t          res;
  } stim_row_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // DUT ports
  logic                     in_valid, in_ready;
  logic [1:0]               action;
  logic [IDX_W-1:0]         point_index, neighbor_index;
  logic [SLOT_W-1:0]        neighbor_slot;
  logic signed [CRD_W-1:0]  coord_x, coord_y, coord_z;
  logic                     out_valid, out_ready;
  logic [IDX_W-1:0]         member_index;
  logic                     done_res;
  logic                     cfg_valid, cfg_ready;
  logic [RAD_W-1:0]         cfg_radius;

  knn_graph_radius_walk DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .action_i             (action),
    .point_index_i        (point_index),
    .neighbor_slot_i      (neighbor_slot),
    .neighbor_index_i     (neighbor_index),
    .coord_x_i            (coord_x),
    .coord_y_i            (coord_y),
    .coord_z_i            (coord_z),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .member_index_o       (member_index),
    .done_res_o           (done_res),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_squared_radius_i (cfg_radius)
  );

  // Shadow state of the walk engine
  logic signed [15:0] pt_x [NPTS], pt_y [NPTS], pt_z [NPTS];
  logic [IDX_W-1:0]   nbr_tab [NPTS*NNBR];
  logic               seen [NPTS];
  logic [IDX_W-1:0]   walk_stk [NPTS];
  int unsigned        walk_depth;
  logic [IDX_W-1:0]   centre;
  logic [RAD_W-1:0]   radius_sh;

  // Reachable set: its points have coords and all slots loaded, slots point inside it
  logic [IDX_W-1:0]   reach [SET_SIZE];
  logic               in_reach [NPTS];

  walk_res_t   expected_members [$];
  int          fails = 0;
  int unsigned tx_idle_pct = 0, rx_idle_pct = 0;
  int unsigned hold_reqs = 0, hold_seen = 0, hold_left = 0;
  longint      cycles = 0;

  // squared distance from the centre, 64-bit so nothing wraps
  function automatic longint sq_from_centre(input logic [IDX_W-1:0] p);
    longint dx, dy, dz;
    dx = longint'(pt_x[centre]) - longint'(pt_x[p]);
    dy = longint'(pt_y[centre]) - longint'(pt_y[p]);
    dz = longint'(pt_z[centre]) - longint'(pt_z[p]);
    return dx*dx + dy*dy + dz*dz;
  endfunction

  // advance the shadow by one accepted beat; has_res tells if a result follows
  task automatic walk_model(input action_e a, input logic [IDX_W-1:0] p,
                            input logic [SLOT_W-1:0] s, input logic [IDX_W-1:0] n,
                            input logic signed [15:0] x, y, z,
                            output logic has_res, output walk_res_t r);
    logic [IDX_W-1:0] cur, nb;
    has_res = 1'b0;
    r = '0;
    case (a)
      ACT_LOAD_POINT: begin
        pt_x[p] = x; pt_y[p] = y; pt_z[p] = z;
      end
      ACT_LOAD_NBR: begin
        nbr_tab[p*NNBR + s] = n;
      end
      default: begin
        if (a == ACT_START) begin
          foreach (seen[i]) seen[i] = 1'b0;
          centre = p;
          seen[p] = 1'b1;
          walk_stk[0] = p;
          walk_depth = 1;
        end
        has_res = 1'b1;
        if (walk_depth == 0) begin
          r.done = 1'b1;
        end else begin
          walk_depth--;
          cur = walk_stk[walk_depth];
          r.idx = cur;
          for (int k = 0; k < NNBR; k++) begin
            nb = nbr_tab[cur*NNBR + k];
            if (!seen[nb] && sq_from_centre(nb) < longint'(radius_sh)) begin
              seen[nb] = 1'b1;
              walk_stk[walk_depth] = nb;
              walk_depth++;
            end
          end
        end
      end
    endcase
  endtask

  // one input beat; the shadow steps at the acceptance edge
  task automatic send_beat(input action_e a, input logic [IDX_W-1:0] p,
                           input logic [SLOT_W-1:0] s, input logic [IDX_W-1:0] n,
                           input logic signed [15:0] x, y, z,
                           output logic has_res, output walk_res_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    action <= a; point_index <= p; neighbor_slot <= s; neighbor_index <= n;
    coord_x <= x; coord_y <= y; coord_z <= z;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    walk_model(a, p, s, n, x, y, z, has_res, r);
  endtask

  task automatic send_checked(input action_e a, input logic [IDX_W-1:0] p,
                              input logic [SLOT_W-1:0] s, input logic [IDX_W-1:0] n,
                              input logic signed [15:0] x, y, z);
    logic has_res;
    walk_res_t r;
    send_beat(a, p, s, n, x, y, z, has_res, r);
    if (has_res) expected_members.push_back(r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_members.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // radius only changes with the block idle
  task automatic write_radius(input logic [RAD_W-1:0] v);
    wait_drained();
    cfg_valid  <= 1'b1;
    cfg_radius <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    radius_sh = v;
  endtask

  // mostly clustered so that finite radii split the graph; sometimes full range
  function automatic logic signed [15:0] rand_coord();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(8191)) - 4096);
  endfunction

  function automatic logic [IDX_W-1:0] rand_reach();
    return reach[$urandom_range(SET_SIZE-1)];
  endfunction

  function automatic logic [RAD_W-1:0] rand_radius();
    case ($urandom_range(5))
      0:       return RAD_W'(1) << 16;
      1:       return RAD_W'(1) << 22;
      2:       return RAD_W'(1) << 24;
      3:       return RAD_W'(1) << 26;
      4:       return {2'($urandom), 32'($urandom)};
      default: return RAD_MAX;
    endcase
  endfunction

  // coords and every slot of every reachable point, so no walk reads unloaded data
  task automatic preload_reach();
    for (int i = 0; i < SET_SIZE; i++) begin
      send_checked(ACT_LOAD_POINT, reach[i], '0, '0, rand_coord(), rand_coord(),
                   rand_coord());
      for (int k = 0; k < NNBR; k++)
        send_checked(ACT_LOAD_NBR, reach[i], SLOT_W'(k), rand_reach(), '0, '0, '0);
    end
  endtask

  // random items: mostly start-then-next walks, the rest loads and stray nexts
  task automatic random_block(input int unsigned n_items);
    int unsigned sent, pick, steps;
    logic [IDX_W-1:0] p;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_checked(ACT_START, rand_reach(), SLOT_W'($urandom), IDX_W'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom));
        sent++;
        steps = ($urandom_range(4) == 0) ? $urandom_range(6) : 64;
        while (steps != 0 && walk_depth != 0) begin
          send_checked(ACT_NEXT, IDX_W'($urandom), SLOT_W'($urandom), IDX_W'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom));
          sent++;
          steps--;
        end
        if (steps != 0) begin
          // one more to see done
          send_checked(ACT_NEXT, IDX_W'($urandom), '0, '0, '0, '0, '0);
          sent++;
        end
      end else if (pick < 80) begin
        send_checked(ACT_LOAD_POINT, ($urandom_range(1) == 0) ? rand_reach()
                     : IDX_W'($urandom), SLOT_W'($urandom), IDX_W'($urandom),
                     rand_coord(), rand_coord(), rand_coord());
        sent++;
      end else if (pick < 92) begin
        p = ($urandom_range(1) == 0) ? rand_reach() : IDX_W'($urandom);
        // keep the reachable set closed
        send_checked(ACT_LOAD_NBR, p, SLOT_W'($urandom),
                     in_reach[p] ? rand_reach() : IDX_W'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end else begin
        send_checked(ACT_NEXT, IDX_W'($urandom), SLOT_W'($urandom), IDX_W'($urandom),
                     '0, '0, '0);
        sent++;
      end
    end
  endtask

  // receiver: random ready, long hold-off on request, in-order check
  always @(posedge clk_i) begin
    walk_res_t e;
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_ni && ($urandom_range(99) >= rx_idle_pct);
    end
    if (rst_ni && out_valid && out_ready) begin
      if (expected_members.size() == 0) begin
        $error("result beat with nothing expected: member_index %0d done_res %0b",
               member_index, done_res);
        fails++;
      end else begin
        e = expected_members.pop_front();
        if (member_index !== e.idx) begin
          $error("member_index: expected %0d, got %0d", e.idx, member_index);
          fails++;
        end
        if (done_res !== e.done) begin
          $error("done_res: expected %0b, got %0b", e.done, done_res);
          fails++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  stim_row_t dir_rows [$];

  function automatic stim_row_t mk_row(input row_kind_e kd, input action_e a,
                                       input logic [IDX_W-1:0] p, input logic [SLOT_W-1:0] s,
                                       input logic [IDX_W-1:0] n,
                                       input logic signed [15:0] x, y, z,
                                       input logic [RAD_W-1:0] rad, input row_chk_e c,
                                       input logic [IDX_W-1:0] ei, input logic ed);
    stim_row_t r;
    r.kind = kd; r.act = a; r.pidx = p; r.slot = s; r.nidx = n;
    r.x = x; r.y = y; r.z = z; r.radius = rad; r.chk = c;
    r.res.idx = ei; r.res.done = ed;
    return r;
  endfunction

  initial begin
    logic has_res;
    walk_res_t r;
    int unsigned idle_tx [3], idle_rx [3];

    in_valid = 1'b0; action = ACT_LOAD_POINT; point_index = '0; neighbor_slot = '0;
    neighbor_index = '0; coord_x = '0; coord_y = '0; coord_z = '0;
    out_ready = 1'b0; cfg_valid = 1'b0; cfg_radius = '0;
    rst_ni = 1'b0;

    walk_depth = 0; centre = '0; radius_sh = '0;
    foreach (seen[i]) begin
      seen[i] = 1'b0; in_reach[i] = 1'b0;
      pt_x[i] = '0; pt_y[i] = '0; pt_z[i] = '0;
    end
    foreach (nbr_tab[i]) nbr_tab[i] = '0;
    reach[0] = '0;
    reach[1] = '1;
    for (int i = 2; i < SET_SIZE; i++) reach[i] = IDX_W'($urandom);
    foreach (reach[i]) in_reach[reach[i]] = 1'b1;

    // Directed part. Radius is 0 out of reset, so a start only returns its centre.
    dir_rows.push_back(mk_row(ROW_ITEM, ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, CHK_TYPED, 0, 1));
    dir_rows.push_back(mk_row(ROW_PRELOAD, ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, CHK_NONE, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, ACT_LOAD_POINT, 0, 0, 0, 32767, 32767, 32767,
                              0, CHK_NONE, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, ACT_LOAD_POINT, 1023, 7, 1023, -32768, -32768,
                              -32768, 0, CHK_NONE, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, ACT_LOAD_NBR, 0, 0, 1023, 0, 0, 0, 0, CHK_NONE, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, ACT_LOAD_NBR, 1023, 7, 0, 0, 0, 0, 0, CHK_NONE, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, ACT_START, 0, 0, 0, 0, 0, 0, 0, CHK_TYPED, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, CHK_TYPED, 0, 1));
    dir_rows.push_back(mk_row(ROW_ITEM, ACT_START, 1023, 7, 1023, -1, -1, -1, 0,
                              CHK_TYPED, 1023, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, ACT_NEXT, 1023, 7, 1023, 0, 0, 0, 0, CHK_TYPED, 0, 1));
    // widest radius: corner-to-corner distance still passes
    dir_rows.push_back(mk_row(ROW_CFG, ACT_NEXT, 0, 0, 0, 0, 0, 0, RAD_MAX, CHK_NONE, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, ACT_START, 0, 0, 0, 0, 0, 0, 0, CHK_MODEL, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, CHK_MODEL, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, CHK_MODEL, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, CHK_MODEL, 0, 0));
    dir_rows.push_back(mk_row(ROW_CFG, ACT_NEXT, 0, 0, 0, 0, 0, 0, 34'd1 << 20,
                              CHK_NONE, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, ACT_LOAD_POINT, 0, 0, 0, 0, 0, 0, 0, CHK_NONE, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, ACT_LOAD_POINT, 1023, 0, 0, -1, 0, 1, 0,
                              CHK_NONE, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, ACT_START, 1023, 0, 0, 0, 0, 0, 0, CHK_MODEL, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, CHK_MODEL, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, CHK_MODEL, 0, 0));
    dir_rows.push_back(mk_row(ROW_ITEM, ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, CHK_MODEL, 0, 0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 11; rx_idle_pct = 64;
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG:     write_radius(dir_rows[i].radius);
        ROW_PRELOAD: preload_reach();
        default: begin
          send_beat(dir_rows[i].act, dir_rows[i].pidx, dir_rows[i].slot, dir_rows[i].nidx,
                    dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, has_res, r);
          if (dir_rows[i].chk == CHK_TYPED) expected_members.push_back(dir_rows[i].res);
          else if (has_res) expected_members.push_back(r);
        end
      endcase
    end

    // Random part: three idling phases, two radius settings each
    idle_tx = '{11, 64, 0};
    idle_rx = '{64, 11, 0};
    for (int ph = 0; ph < 3; ph++) begin
      for (int b = 0; b < 2; b++) begin
        write_radius((ph == 2 && b == 1) ? RAD_MAX : rand_radius());
        tx_idle_pct = idle_tx[ph];
        rx_idle_pct = idle_rx[ph];
        // back-pressure: receiver stops while the sender keeps offering
        if (ph == 2 && b == 0) hold_reqs++;
        random_block(233);
      end
    end

    wait_drained();
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/kgrw_pkg.sv
rtl/kgrw_ram.sv
rtl/kgrw_dist.sv
rtl/knn_graph_radius_walk.sv
tb/sv/tb_top.sv
